/* rtl/core/ledpwm_pkg.sv */
`timescale 1ns / 1ps

package ledpwm_pkg;

   localparam int CHANNELS_DEF = 4;
   localparam int LEVELS_DEF   = 19;

   // Pins visible on the ports
   localparam int PIN_COUNT    = 4;

   typedef enum logic [1:0] {
      KIND_STEADY = 2'd0,
      KIND_PWM    = 2'd1,
      KIND_TICK   = 2'd2
   } kind_type;

   typedef struct packed {
      logic [PIN_COUNT-1:0] led_pins;
      logic [PIN_COUNT-1:0] pwm_active;
   } result_type;

   // Perceptual intensity curve; entries past the list read as full on
   function automatic logic [7:0] level_duty(input logic [4:0] idx);
      logic [7:0] duty;
      case (idx)
         5'd0:    duty = 8'd0;
         5'd1:    duty = 8'd6;
         5'd2:    duty = 8'd14;
         5'd3:    duty = 8'd24;
         5'd4:    duty = 8'd34;
         5'd5:    duty = 8'd45;
         5'd6:    duty = 8'd57;
         5'd7:    duty = 8'd70;
         5'd8:    duty = 8'd83;
         5'd9:    duty = 8'd96;
         5'd10:   duty = 8'd111;
         5'd11:   duty = 8'd127;
         5'd12:   duty = 8'd142;
         5'd13:   duty = 8'd160;
         5'd14:   duty = 8'd178;
         5'd15:   duty = 8'd191;
         5'd16:   duty = 8'd216;
         5'd17:   duty = 8'd237;
         default: duty = 8'd255;
      endcase
      return duty;
   endfunction

endpackage

/* rtl/core/four_channel_led_pwm_dimmer_core.sv */
`timescale 1ns / 1ps

// Channel   Signals                                   Direction
// req_      valid, stall, kind, channel_mask,         in (stall out)
//           steady_level, intensity_index
// rsp_      valid, stall, led_pins, pwm_active        out (stall in)
// csr_      wr_en, wr_data (deadband)                 in
//
// One transaction is taken per cycle while req_stall is low; its result is
// registered into the result buffer. The state update and the pin compare
// sit between the state registers and a two-entry result buffer, so
// req_stall rises only when both entries are full. Synchronous reset clears
// all state, the deadband to 2, and empties the result buffer.

module four_channel_led_pwm_dimmer_core
   import ledpwm_pkg::*;
#(
   parameter int CHANNELS = CHANNELS_DEF,
   parameter int LEVELS   = LEVELS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_kind,
   input  logic [3:0]           req_channel_mask,
   input  logic                 req_steady_level,
   input  logic [4:0]           req_intensity_index,

   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [PIN_COUNT-1:0] rsp_led_pins,
   output logic [PIN_COUNT-1:0] rsp_pwm_active,

   input  logic                 csr_wr_en,
   input  logic [7:0]           csr_wr_data
);

   localparam int ACTIVE = (CHANNELS > PIN_COUNT) ? PIN_COUNT : CHANNELS;
   localparam logic [PIN_COUNT-1:0] ACT_MASK = PIN_COUNT'((1 << ACTIVE) - 1);
   localparam logic [5:0] LEVELS_W = 6'(LEVELS);
   localparam logic [4:0] TOP_IDX  = 5'(LEVELS - 1);

   logic [7:0]           deadband_ff;
   logic [7:0]           duty_ff [ACTIVE];
   logic [7:0]           duty_in [ACTIVE];
   logic [7:0]           diff [ACTIVE];
   logic [PIN_COUNT-1:0] mode_ff, mode_in;
   logic [PIN_COUNT-1:0] steady_ff, steady_in;
   logic [7:0]           count_ff, count_in;

   result_type           main_ff, skid_ff, result;
   logic                 main_valid_ff, skid_valid_ff;

   logic                 accept;
   logic                 drain;
   kind_type             kind;
   logic [PIN_COUNT-1:0] masked;
   logic [PIN_COUNT-1:0] lowest;
   logic [4:0]           sat_idx;
   logic [7:0]           new_duty;
   logic [PIN_COUNT-1:0] pins;

   assign req_stall      = skid_valid_ff;
   assign accept         = req_valid && !skid_valid_ff;
   assign drain          = main_valid_ff && !rsp_stall;
   assign rsp_valid      = main_valid_ff;
   assign rsp_led_pins   = main_ff.led_pins;
   assign rsp_pwm_active = main_ff.pwm_active;

   assign kind     = kind_type'(req_kind);
   assign masked   = req_channel_mask & ACT_MASK;
   assign lowest   = masked & (~masked + PIN_COUNT'(1));
   assign sat_idx  = ({1'b0, req_intensity_index} >= LEVELS_W) ? TOP_IDX
                                                              : req_intensity_index;
   assign new_duty = level_duty(sat_idx);

   always_comb begin
      mode_in   = mode_ff;
      steady_in = steady_ff;
      count_in  = count_ff;
      case (kind)
         KIND_STEADY: begin
            // only the lowest addressed channel is touched
            steady_in = req_steady_level ? (steady_ff | lowest) : (steady_ff & ~lowest);
            mode_in   = mode_ff & ~lowest;
         end
         KIND_PWM: begin
            mode_in = mode_ff | masked;
         end
         KIND_TICK: begin
            count_in = count_ff + 8'd1;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      for (int c = 0; c < ACTIVE; c++) begin
         diff[c] = (new_duty > duty_ff[c]) ? (new_duty - duty_ff[c])
                                           : (duty_ff[c] - new_duty);
         duty_in[c] = duty_ff[c];
         if (kind == KIND_PWM && masked[c] && diff[c] > deadband_ff) begin
            duty_in[c] = new_duty;
         end
      end
   end

   always_comb begin
      pins = '0;
      for (int c = 0; c < ACTIVE; c++) begin
         pins[c] = mode_in[c] ? (count_in <= duty_in[c]) : steady_in[c];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < ACTIVE; c++) begin
            duty_ff[c] <= 8'd0;
         end
      end else if (accept) begin
         for (int c = 0; c < ACTIVE; c++) begin
            duty_ff[c] <= duty_in[c];
         end
      end
   end

   assign result.led_pins   = pins;
   assign result.pwm_active = mode_in & ACT_MASK;

   always_ff @(posedge clock) begin
      if (reset) begin
         deadband_ff <= 8'd2;
      end else if (csr_wr_en) begin
         deadband_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= '0;
         steady_ff <= '0;
         count_ff  <= 8'd0;
      end else if (accept) begin
         mode_ff   <= mode_in;
         steady_ff <= steady_in;
         count_ff  <= count_in;
      end
   end

   // Result buffer: main entry drives the port, skid holds a second transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (skid_valid_ff) begin
            if (drain) begin
               main_ff       <= skid_ff;
               skid_valid_ff <= 1'b0;
            end
         end else if (accept) begin
            if (!main_valid_ff || drain) begin
               main_ff       <= result;
               main_valid_ff <= 1'b1;
            end else begin
               skid_ff       <= result;
               skid_valid_ff <= 1'b1;
            end
         end else if (drain) begin
            main_valid_ff <= 1'b0;
         end
      end
   end

endmodule

/* tb/sv/four_channel_led_pwm_dimmer_core_tb.sv */
`timescale 1ns / 1ps

module four_channel_led_pwm_dimmer_core_tb;
   import ledpwm_pkg::*;

   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam int         TOP_LEVEL   = 18;
   localparam int         HOLD_CYCLES = 80;
   localparam int         DRAIN_LIMIT = 2000;
   localparam int         PHASE_ITEMS = 340;

   // Perceived-brightness curve, entry 0 in the low byte
   localparam logic [19*8-1:0] BRIGHTNESS_CURVE = {
      8'd255, 8'd237, 8'd216, 8'd191, 8'd178, 8'd160, 8'd142, 8'd127, 8'd111, 8'd96,
      8'd83,  8'd70,  8'd57,  8'd45,  8'd34,  8'd24,  8'd14,  8'd6,   8'd0
   };

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [1:0] req_kind;
   logic [3:0] req_channel_mask;
   logic       req_steady_level;
   logic [4:0] req_intensity_index;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [3:0] rsp_led_pins;
   logic [3:0] rsp_pwm_active;
   logic       csr_wr_en;
   logic [7:0] csr_wr_data;

   // Shadow of the dimmer state
   logic [7:0] duty_shadow [4];
   logic [3:0] pwm_mode_shadow;
   logic [3:0] steady_shadow;
   logic [7:0] counter_shadow;
   logic [7:0] deadband_shadow;

   result_type expected_pins [$];
   int         mismatch_count;
   bit         sender_gaps;
   bit         receiver_stalls;
   int         stall_left;
   int         hold_request;

   four_channel_led_pwm_dimmer_core i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_kind            (req_kind),
      .req_channel_mask    (req_channel_mask),
      .req_steady_level    (req_steady_level),
      .req_intensity_index (req_intensity_index),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_led_pins        (rsp_led_pins),
      .rsp_pwm_active      (rsp_pwm_active),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // Apply one command to the shadow state and return the pins it leaves
   function automatic result_type dimmer_apply(input logic [1:0] kind, input logic [3:0] mask,
                                               input logic level, input logic [4:0] idx);
      result_type  pins;
      logic [7:0]  duty;
      int unsigned diff;
      int          slot;
      bit          found;
      found = 1'b0;
      slot  = (idx > TOP_LEVEL) ? TOP_LEVEL : idx;
      duty  = BRIGHTNESS_CURVE[slot*8 +: 8];
      case (kind)
         KIND_STEADY: begin
            // only the lowest masked channel is touched
            for (int i = 0; i < 4; i++) begin
               if (mask[i] && !found) begin
                  steady_shadow[i]   = level;
                  pwm_mode_shadow[i] = 1'b0;
                  found              = 1'b1;
               end
            end
         end
         KIND_PWM: begin
            for (int i = 0; i < 4; i++) begin
               if (mask[i]) begin
                  pwm_mode_shadow[i] = 1'b1;
                  diff = (duty > duty_shadow[i]) ? duty - duty_shadow[i]
                                                 : duty_shadow[i] - duty;
                  if (diff > deadband_shadow)
                     duty_shadow[i] = duty;
               end
            end
         end
         KIND_TICK: counter_shadow = counter_shadow + 8'd1;
         default: ;
      endcase
      for (int i = 0; i < 4; i++) begin
         if (pwm_mode_shadow[i])
            pins.led_pins[i] = (counter_shadow <= duty_shadow[i]);
         else
            pins.led_pins[i] = steady_shadow[i];
      end
      pins.pwm_active = pwm_mode_shadow;
      return pins;
   endfunction

   task automatic offer_command(input logic [1:0] kind, input logic [3:0] mask,
                                input logic level, input logic [4:0] idx);
      int gap;
      gap = sender_gaps ? $urandom_range(0, 10) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid           <= 1'b1;
      req_kind            <= kind;
      req_channel_mask    <= mask;
      req_steady_level    <= level;
      req_intensity_index <= idx;
      do @(posedge clock); while (req_stall);
      expected_pins.push_back(dimmer_apply(kind, mask, level, idx));
   endtask

   task automatic random_command();
      logic [1:0] kind;
      int         pick;
      pick = $urandom_range(0, 99);
      if (pick < 40)
         kind = KIND_TICK;
      else if (pick < 70)
         kind = KIND_PWM;
      else if (pick < 95)
         kind = KIND_STEADY;
      else
         kind = KIND_UNUSED;
      offer_command(kind, 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                    ($urandom_range(0, 9) == 0) ? 5'($urandom_range(19, 31))
                                                : 5'($urandom_range(0, TOP_LEVEL)));
   endtask

   // Let every outstanding transaction come back before touching the register
   task automatic drain_results();
      int waited;
      waited = 0;
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_pins.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (expected_pins.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, expected_pins.size());
         mismatch_count += expected_pins.size();
         expected_pins.delete();
      end
      repeat (4) @(negedge clock);
   endtask

   task automatic write_deadband(input logic [7:0] value);
      drain_results();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      deadband_shadow = value;
   endtask

   task automatic test_reset_state();
      offer_command(KIND_UNUSED, 4'b1111, 1'b1, 5'd31);
      offer_command(KIND_TICK, 4'b0000, 1'b0, 5'd0);
      offer_command(KIND_STEADY, 4'b0000, 1'b1, 5'd0);
      offer_command(KIND_PWM, 4'b0000, 1'b0, 5'd9);
   endtask

   task automatic test_directed_cases();
      offer_command(KIND_STEADY, 4'b1111, 1'b1, 5'd0);
      offer_command(KIND_STEADY, 4'b1000, 1'b1, 5'd0);
      offer_command(KIND_STEADY, 4'b0110, 1'b1, 5'd0);
      offer_command(KIND_PWM, 4'b1111, 1'b0, 5'd18);
      offer_command(KIND_TICK, 4'b1111, 1'b1, 5'd0);
      // saturated index lands on full scale, kept within the deadband
      offer_command(KIND_PWM, 4'b0001, 1'b0, 5'd31);
      offer_command(KIND_PWM, 4'b0010, 1'b0, 5'd0);
      offer_command(KIND_PWM, 4'b0100, 1'b0, 5'd1);
      offer_command(KIND_PWM, 4'b1000, 1'b0, 5'd17);
      offer_command(KIND_PWM, 4'b1000, 1'b0, 5'd19);
      offer_command(KIND_STEADY, 4'b1000, 1'b0, 5'd0);
      offer_command(KIND_PWM, 4'b1000, 1'b1, 5'd18);
      offer_command(KIND_UNUSED, 4'b1111, 1'b1, 5'd31);
      write_deadband(8'd10);
      offer_command(KIND_PWM, 4'b0100, 1'b0, 5'd2);
      offer_command(KIND_PWM, 4'b0100, 1'b0, 5'd3);
      offer_command(KIND_STEADY, 4'b0001, 1'b0, 5'd0);
      offer_command(KIND_STEADY, 4'b0001, 1'b1, 5'd0);
   endtask

   // One full counter period: every compare point, the wrap, and duty zero at count 0
   task automatic test_counter_sweep();
      write_deadband(8'd0);
      offer_command(KIND_PWM, 4'b0001, 1'b0, 5'd0);
      offer_command(KIND_PWM, 4'b0010, 1'b0, 5'd9);
      offer_command(KIND_PWM, 4'b0100, 1'b0, 5'd15);
      offer_command(KIND_PWM, 4'b1000, 1'b0, 5'd18);
      sender_gaps     = 1'b0;
      receiver_stalls = 1'b0;
      repeat (258) offer_command(KIND_TICK, 4'b0000, 1'b0, 5'd0);
   endtask

   task automatic test_backpressure();
      drain_results();
      sender_gaps  = 1'b0;
      hold_request = HOLD_CYCLES;
      repeat (40) random_command();
   endtask

   task automatic test_deadband_sweep();
      logic [7:0] settings [4];
      settings[0] = 8'd0;
      settings[1] = 8'd255;
      settings[2] = 8'd1;
      settings[3] = 8'($urandom_range(3, 60));
      for (int s = 0; s < 4; s++) begin
         write_deadband(settings[s]);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // switch idle behaviour now and then, leaving some stretches flat out
            if (n % 50 == 0) begin
               sender_gaps     = ($urandom_range(0, 2) != 0);
               receiver_stalls = ($urandom_range(0, 2) != 0);
            end
            random_command();
         end
      end
   endtask

   // Receiver: per-transaction stall, plus a long hold-off on request
   initial begin : rsp_side
      int hold_left;
      hold_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : check_rsp
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         stall_left = receiver_stalls ? $urandom_range(0, 10) : 0;
         if (expected_pins.size() == 0) begin
            $display("%0t: unexpected transaction, pins %h active %h",
                     $time, rsp_led_pins, rsp_pwm_active);
            mismatch_count++;
         end else begin
            want = expected_pins.pop_front();
            if (rsp_led_pins !== want.led_pins) begin
               $display("%0t: led_pins expected %h, got %h",
                        $time, want.led_pins, rsp_led_pins);
               mismatch_count++;
            end
            if (rsp_pwm_active !== want.pwm_active) begin
               $display("%0t: pwm_active expected %h, got %h",
                        $time, want.pwm_active, rsp_pwm_active);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      reset               = 1'b1;
      req_valid           = 1'b0;
      req_kind            = KIND_STEADY;
      req_channel_mask    = 4'b0000;
      req_steady_level    = 1'b0;
      req_intensity_index = 5'd0;
      csr_wr_en           = 1'b0;
      csr_wr_data         = 8'd0;
      sender_gaps         = 1'b1;
      receiver_stalls     = 1'b1;
      stall_left          = 0;
      hold_request        = 0;
      mismatch_count      = 0;
      pwm_mode_shadow     = 4'b0000;
      steady_shadow       = 4'b0000;
      counter_shadow      = 8'd0;
      deadband_shadow     = 8'd2;
      for (int i = 0; i < 4; i++) duty_shadow[i] = 8'd0;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_directed_cases();
      test_counter_sweep();
      test_backpressure();
      test_deadband_sweep();

      drain_results();
      if (mismatch_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
